// File: rtl/cbrm_pkg.sv
// ----------------------------------------------------------------------------
// cbrm_pkg
// Types, codes and constants shared by the cash bag removal monitor files.
// ----------------------------------------------------------------------------
package cbrm_pkg;

  localparam int SENSOR_W    = 3;
  localparam int LIMIT_W     = 16;
  localparam int CFG_INDEX_W = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_GAP       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_CONFIRM = 8'd1;

  localparam logic [LIMIT_W-1:0] OPEN_GAP_RESET       = 16'd10000;
  localparam logic [LIMIT_W-1:0] CLOSED_CONFIRM_RESET = 16'd40000;

  typedef enum logic [2:0] {
    MODE_INPLACE = 3'd0,
    MODE_TSTART  = 3'd1,
    MODE_TSTEP1  = 3'd2,
    MODE_REMOVED = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_EX00,
    ST_ERR,
    ST_EX01,
    ST_OPEN,
    ST_EX10,
    ST_EX11,
    ST_CLOSED
  } status_t;

  typedef logic [2:0] event_t;

  localparam event_t EV_NONE       = 3'd0;
  localparam event_t EV_REMOVED    = 3'd1;
  localparam event_t EV_INPLACE    = 3'd2;
  localparam event_t EV_DOOR_OPEN  = 3'd3;
  localparam event_t EV_PUT_CLOSED = 3'd4;
  localparam event_t EV_UNEXPECTED = 3'd5;
  localparam event_t EV_BAD_START  = 3'd6;

  typedef struct packed {
    mode_t  bag_mode;
    logic   beep_request;
    logic   clear_approval;
    event_t event_code;
  } result_t;

  // sensor pattern ABC to status
  function automatic status_t status_of(logic [SENSOR_W-1:0] bits);
    status_t st;
    case (bits)
      3'b000:  st = ST_EX00;
      3'b001:  st = ST_ERR;
      3'b010:  st = ST_EX01;
      3'b011:  st = ST_OPEN;
      3'b100:  st = ST_EX10;
      3'b101:  st = ST_ERR;
      3'b110:  st = ST_EX11;
      default: st = ST_CLOSED;
    endcase
    return st;
  endfunction

endpackage

// File: rtl/cbrm_if.sv
// ----------------------------------------------------------------------------
// cbrm channel interfaces
// Valid/ready channels for sensor ticks, results and register writes.
// ----------------------------------------------------------------------------
interface cbrm_in_if import cbrm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface cbrm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bag_mode;
  logic       beep_request;
  logic       clear_approval;
  logic [2:0] event_code;

  modport source (output valid, output bag_mode, output beep_request,
                  output clear_approval, output event_code, input ready);
  modport sink   (input valid, input bag_mode, input beep_request,
                  input clear_approval, input event_code, output ready);
endinterface

interface cbrm_cfg_if import cbrm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [LIMIT_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/cbrm_seq.sv
// ----------------------------------------------------------------------------
// cbrm_seq
// Removal sequencer: mode, debounce counters and armed flag, one tick a step.
// ----------------------------------------------------------------------------
module cbrm_seq import cbrm_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [SENSOR_W-1:0] sensor_bits,
  input  logic [LIMIT_W-1:0]  open_gap_limit,
  input  logic [LIMIT_W-1:0]  closed_confirm_limit,
  output result_t             result
);

  localparam int LW = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam logic [LW-1:0] CNT_MAX = LW'({COUNT_WIDTH{1'b1}});

  mode_t                  mode_r, mode_nxt;
  logic                   started_r;
  logic [COUNT_WIDTH-1:0] gap_r, gap_nxt;
  logic [COUNT_WIDTH-1:0] closed_r, closed_nxt;
  logic                   armed_r, armed_nxt;
  event_t                 ev;
  status_t                st;
  logic [LW-1:0]          glim_ext, clim_ext;
  logic [COUNT_WIDTH-1:0] glim, clim;

  // limits clipped to the counter range
  assign glim_ext = LW'(open_gap_limit);
  assign clim_ext = LW'(closed_confirm_limit);
  assign glim = (glim_ext < CNT_MAX) ? glim_ext[COUNT_WIDTH-1:0] : CNT_MAX[COUNT_WIDTH-1:0];
  assign clim = (clim_ext < CNT_MAX) ? clim_ext[COUNT_WIDTH-1:0] : CNT_MAX[COUNT_WIDTH-1:0];

  assign st = status_of(sensor_bits);

  always_comb begin
    mode_nxt   = mode_r;
    gap_nxt    = gap_r;
    closed_nxt = closed_r;
    armed_nxt  = armed_r;
    ev         = EV_NONE;
    if (!started_r) begin
      // first tick only picks the start mode
      if (st == ST_OPEN) begin
        mode_nxt = MODE_INPLACE;
      end else if (st == ST_EX00) begin
        mode_nxt = MODE_REMOVED;
      end else begin
        mode_nxt = MODE_ERROR;
        ev       = EV_BAD_START;
      end
    end else begin
      unique case (mode_r)
        MODE_INPLACE: begin
          case (st)
            ST_OPEN: begin
              closed_nxt = '0;
              gap_nxt    = '0;
              armed_nxt  = 1'b1;
            end
            ST_EX01: begin
              if (gap_r < glim) gap_nxt = gap_r + COUNT_WIDTH'(1);
            end
            ST_CLOSED: begin
              if (closed_r < clim) closed_nxt = closed_r + COUNT_WIDTH'(1);
              else mode_nxt = MODE_TSTART;
            end
            ST_EX11: mode_nxt = MODE_TSTART;
            ST_EX00: begin
              if (armed_r) begin
                armed_nxt = 1'b0;
                mode_nxt  = MODE_ERROR;
                ev        = EV_DOOR_OPEN;
              end
            end
            default: begin
              mode_nxt = MODE_ERROR;
              ev       = EV_UNEXPECTED;
            end
          endcase
        end
        MODE_TSTART: begin
          case (st) inside
            ST_EX11, ST_CLOSED: begin
            end
            ST_EX01: mode_nxt = MODE_TSTEP1;
            ST_EX10: begin
              if (armed_r) begin
                armed_nxt = 1'b0;
                mode_nxt  = MODE_ERROR;
                ev        = EV_DOOR_OPEN;
              end
            end
            default: begin
              mode_nxt = MODE_ERROR;
              ev       = EV_UNEXPECTED;
            end
          endcase
        end
        MODE_TSTEP1: begin
          case (st)
            ST_EX11: mode_nxt = MODE_TSTART;
            ST_EX01: begin
            end
            ST_EX00: begin
              mode_nxt = MODE_REMOVED;
              ev       = EV_REMOVED;
            end
            default: begin
              mode_nxt = MODE_ERROR;
              ev       = EV_UNEXPECTED;
            end
          endcase
        end
        MODE_REMOVED: begin
          case (st) inside
            ST_EX00, ST_EX11: begin
            end
            ST_EX10: begin
              if (armed_r) begin
                armed_nxt = 1'b0;
                mode_nxt  = MODE_ERROR;
                ev        = EV_DOOR_OPEN;
              end
            end
            ST_EX01: armed_nxt = 1'b0;
            ST_OPEN: begin
              mode_nxt = MODE_INPLACE;
              ev       = EV_INPLACE;
            end
            ST_CLOSED: begin
              mode_nxt = MODE_ERROR;
              ev       = EV_PUT_CLOSED;
            end
            default: begin
              mode_nxt = MODE_ERROR;
              ev       = EV_UNEXPECTED;
            end
          endcase
        end
        MODE_ERROR: begin
          if (st == ST_EX00) mode_nxt = MODE_REMOVED;
        end
        default: begin
          mode_nxt = MODE_ERROR;
          ev       = EV_UNEXPECTED;
        end
      endcase
    end
  end

  assign result.bag_mode       = mode_nxt;
  assign result.beep_request   = (mode_nxt != MODE_INPLACE) || (gap_nxt >= glim);
  assign result.clear_approval = (mode_nxt == MODE_REMOVED);
  assign result.event_code     = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_INPLACE;
      started_r <= 1'b0;
      gap_r     <= '0;
      closed_r  <= '0;
      armed_r   <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      started_r <= 1'b1;
      gap_r     <= gap_nxt;
      closed_r  <= closed_nxt;
      armed_r   <= armed_nxt;
    end
  end

endmodule

// File: rtl/cash_bag_removal_monitor.sv
// ----------------------------------------------------------------------------
// cash_bag_removal_monitor
// Tracks a cash bag being taken out from three polled sensor bits per tick.
// ----------------------------------------------------------------------------
//  channel   | direction | payload                                   | handshake
//  ----------+-----------+-------------------------------------------+----------
//  in_chan   | in        | sensor_bits[2:0]                          | valid/ready
//  out_chan  | out       | bag_mode, beep_request, clear_approval,   | valid/ready
//            |           | event_code                                |
//  cfg_chan  | in        | reg_index[7:0], wdata[15:0]               | valid/ready
//
//  one tick per cycle sustained while out_chan is not stalled; a tick taken
//  goes into the input register, then through the sequencer step into the
//  result register, which drives its result transaction on out_chan
//  rst_n is synchronous, active low; no clearing pass, limits reload defaults
//  a stalled result holds in the result register; the input register takes
//  at most one more tick, and in_chan.ready stays low while it is full until
//  out_chan.ready returns; cfg is always ready
// ----------------------------------------------------------------------------
module cash_bag_removal_monitor import cbrm_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  cbrm_cfg_if.sink          cfg_chan,
  cbrm_in_if.sink           in_chan,
  cbrm_out_if.source        out_chan
);

  // configuration registers
  logic [LIMIT_W-1:0] open_gap_limit_r;
  logic [LIMIT_W-1:0] closed_confirm_limit_r;

  // input register stage
  logic                in_valid_r;
  logic [SENSOR_W-1:0] in_bits_r;
  logic                in_ready;

  // result register stage
  logic    out_valid_r;
  result_t out_res_r;
  result_t step_res;

  // a tick leaves the input register when the result register is free or draining
  logic advance;

  assign advance  = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !in_valid_r || advance;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_gap_limit_r       <= OPEN_GAP_RESET;
      closed_confirm_limit_r <= CLOSED_CONFIRM_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        REG_OPEN_GAP:       open_gap_limit_r       <= cfg_chan.wdata;
        REG_CLOSED_CONFIRM: closed_confirm_limit_r <= cfg_chan.wdata;
        default: begin
        end
      endcase
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_chan.valid;
      if (!out_valid_r || out_chan.ready) out_valid_r <= in_valid_r;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) in_bits_r <= in_chan.sensor_bits;
    if (advance) out_res_r <= step_res;
  end

  // sequencer steps exactly once per transaction moved into the result register
  cbrm_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .step                 (advance),
    .sensor_bits          (in_bits_r),
    .open_gap_limit       (open_gap_limit_r),
    .closed_confirm_limit (closed_confirm_limit_r),
    .result               (step_res)
  );

  assign out_chan.valid          = out_valid_r;
  assign out_chan.bag_mode       = out_res_r.bag_mode;
  assign out_chan.beep_request   = out_res_r.beep_request;
  assign out_chan.clear_approval = out_res_r.clear_approval;
  assign out_chan.event_code     = out_res_r.event_code;

endmodule

// File: rtl/cbrm_checker.sv
// ----------------------------------------------------------------------------
// cbrm_assert
// Port-level checks on the result channel of the monitor.
// ----------------------------------------------------------------------------
module cbrm_assert import cbrm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] bag_mode,
  input logic       beep_request,
  input logic       clear_approval,
  input logic [2:0] event_code
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bag_mode)
      && $stable(event_code) && $stable(beep_request) && $stable(clear_approval))
    else $error("result changed while stalled");

  // clear approval follows the removed mode
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (clear_approval == (bag_mode == MODE_REMOVED)))
    else $error("clear approval does not match mode");

  // any mode but in place beeps
  a_beep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (bag_mode != MODE_INPLACE) |-> beep_request)
    else $error("missing beep request");

  // events agree with the mode they lead to
  a_event_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((event_code != EV_REMOVED) || (bag_mode == MODE_REMOVED)) &&
      ((event_code != EV_INPLACE) || (bag_mode == MODE_INPLACE)) &&
      (!((event_code == EV_DOOR_OPEN) || (event_code == EV_PUT_CLOSED) ||
         (event_code == EV_UNEXPECTED) || (event_code == EV_BAD_START))
       || (bag_mode == MODE_ERROR)))
    else $error("event code inconsistent with mode");

endmodule

bind cash_bag_removal_monitor cbrm_assert u_cbrm_assert (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .bag_mode       (out_chan.bag_mode),
  .beep_request   (out_chan.beep_request),
  .clear_approval (out_chan.clear_approval),
  .event_code     (out_chan.event_code)
);
